### design/lzw_encoder_9_to_12_bit_defines.svh
// ----------------------------------------------------------------------------
// LZW encoder assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LZW_ENCODER_9_TO_12_BIT_DEFINES_SVH
`define LZW_ENCODER_9_TO_12_BIT_DEFINES_SVH

// same-cycle implication
`define LZWE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// LZW encoder package
// Widths, word types, dictionary slot layout and the hash function.
// ----------------------------------------------------------------------------
package lzwe_pkg;

  localparam int MAX_BITS   = 12;
  localparam int CODE_W     = MAX_BITS;
  localparam int NF_W       = MAX_BITS + 1;
  localparam int BITS_W     = 4;
  localparam int KEY_W      = CODE_W + 8;
  localparam int HASH_W     = MAX_BITS + 1;
  localparam int EP_W       = 8;
  localparam int OFIFO_D    = 4;
  localparam int OFIFO_AW   = 2;

  localparam logic [BITS_W-1:0] START_BITS = BITS_W'(9);
  localparam logic [BITS_W-1:0] TOP_BITS   = BITS_W'(MAX_BITS);
  localparam logic [NF_W-1:0]   FIRST_CODE = NF_W'(256);
  localparam logic [EP_W-1:0]   EP_FIRST   = EP_W'(1);
  localparam logic [EP_W-1:0]   EP_LAST    = '1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BITS_W-1:0] code_bits;
    logic              run_last;
    logic              block_done;
  } out_word_t;

  typedef struct packed {
    logic [EP_W-1:0]   epoch;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } slot_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_FETCH,
    ST_PROBE
  } core_state_t;

  function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] key);
    return HASH_W'(key[KEY_W-1:8]) ^ (HASH_W'(key[7:0]) << 5);
  endfunction

endpackage

### design/lzwe_in_if.sv
// ----------------------------------------------------------------------------
// LZW encoder byte channel
// Valid/ready channel carrying one raw byte and its block end flag.
// ----------------------------------------------------------------------------
interface lzwe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

### design/lzwe_out_if.sv
// ----------------------------------------------------------------------------
// LZW encoder code channel
// Valid/ready channel carrying one code word with its width and flags.
// ----------------------------------------------------------------------------
interface lzwe_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] code;
  logic [3:0]  code_bits;
  logic        run_last;
  logic        block_done;

  modport source (output valid, output code, output code_bits, output run_last,
                  output block_done, input ready);
  modport sink (input valid, input code, input code_bits, input run_last,
                input block_done, output ready);
endinterface

### design/lzwe_in_fifo.sv
// ----------------------------------------------------------------------------
// LZW encoder input queue
// Two-entry queue decoupling the byte channel from the dictionary engine.
// ----------------------------------------------------------------------------
module lzwe_in_fifo (
  input  logic             clk,
  input  logic             rst,
  lzwe_in_if.sink          byte_in,
  input  logic             pop,
  output logic             avail,
  output lzwe_pkg::in_word_t head
);
  import lzwe_pkg::*;

  in_word_t   slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;

  assign byte_in.ready = (count != 2'd2);
  assign push  = byte_in.valid && byte_in.ready;
  assign avail = (count != 2'd0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= '{data_byte: byte_in.data_byte, block_end: byte_in.block_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

### design/lzwe_core.sv
// ----------------------------------------------------------------------------
// LZW encoder dictionary engine
// Hashed dictionary with linear probing and epoch marks; emits up to two
// codes per byte into the output queue.
// ----------------------------------------------------------------------------
module lzwe_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  lzwe_pkg::in_word_t  head,
  output logic                pop,
  input  logic                out_room,
  output lzwe_pkg::push_t     push
);
  import lzwe_pkg::*;

  slot_t             mem [2**HASH_W];
  slot_t             rdata;
  logic [HASH_W-1:0] rd_addr;
  logic              we;
  logic [HASH_W-1:0] wa;
  slot_t             wd;

  core_state_t       state;
  core_state_t       state_next;
  logic [HASH_W-1:0] clr_addr;
  logic [HASH_W-1:0] probe_addr;
  logic [HASH_W-1:0] probe_addr_next;
  logic [EP_W-1:0]   epoch;
  logic [NF_W-1:0]   next_free;
  logic [NF_W-1:0]   next_free_next;
  logic [BITS_W-1:0] width_now;
  logic [BITS_W-1:0] width_now_next;
  logic [CODE_W-1:0] pending_code;
  logic [CODE_W-1:0] pending_code_next;
  logic              at_root;
  logic              at_root_next;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [KEY_W-1:0]  key_q;

  logic              fire;
  logic              slot_live;
  logic              match;
  logic              collide;
  logic              miss;
  logic [NF_W-1:0]   nf_inc;
  logic [BITS_W-1:0] width_inc;
  logic              ovf;
  logic              restart;
  logic              clr_done;

  assign fire      = (state == ST_FETCH) && avail && out_room;
  assign slot_live = (rdata.epoch == epoch);
  assign match     = (state == ST_PROBE) && slot_live && (rdata.key == key_q);
  assign collide   = (state == ST_PROBE) && slot_live && (rdata.key != key_q);
  assign miss      = (state == ST_PROBE) && !slot_live;
  assign nf_inc    = next_free + NF_W'(1);
  assign width_inc = (nf_inc >= (NF_W'(1) << width_now)) ? width_now + BITS_W'(1) : width_now;
  assign ovf       = (width_inc > TOP_BITS);
  assign restart   = (fire && at_root && head.block_end) || (match && last_q) ||
                     (miss && (ovf || last_q));
  assign clr_done  = (state == ST_CLEAR) && (clr_addr == '1);
  assign pop       = fire;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_done) state_next = ST_FETCH;
      ST_FETCH: begin
        if (fire && !at_root) state_next = ST_PROBE;
        else if (restart && epoch == EP_LAST) state_next = ST_CLEAR;
      end
      ST_PROBE: begin
        if (collide) state_next = ST_PROBE;
        else if (restart && epoch == EP_LAST) state_next = ST_CLEAR;
        else state_next = ST_FETCH;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    push              = '0;
    we                = 1'b0;
    wa                = clr_addr;
    wd                = '0;
    rd_addr           = probe_addr;
    probe_addr_next   = probe_addr;
    pending_code_next = pending_code;
    at_root_next      = at_root;
    next_free_next    = next_free;
    width_now_next    = width_now;
    case (state)
      ST_CLEAR: we = 1'b1;
      ST_FETCH: begin
        rd_addr         = key_hash({pending_code, head.data_byte});
        probe_addr_next = rd_addr;
        if (fire && at_root) begin
          pending_code_next = CODE_W'(head.data_byte);
          at_root_next      = 1'b0;
          if (head.block_end) begin
            push.cnt = 2'd1;
            push.w0  = '{code: CODE_W'(head.data_byte), code_bits: width_now,
                         run_last: 1'b1, block_done: 1'b1};
          end
        end
      end
      ST_PROBE: begin
        if (collide) begin
          rd_addr         = probe_addr + HASH_W'(1);
          probe_addr_next = rd_addr;
        end else if (match) begin
          pending_code_next = rdata.code;
          if (last_q) begin
            push.cnt = 2'd1;
            push.w0  = '{code: rdata.code, code_bits: width_now,
                         run_last: 1'b1, block_done: 1'b1};
          end
        end else begin
          we = 1'b1;
          wa = probe_addr;
          wd = '{epoch: epoch, key: key_q, code: next_free[CODE_W-1:0]};
          push.w0 = '{code: pending_code, code_bits: width_now,
                      run_last: 1'b0, block_done: 1'b0};
          next_free_next    = nf_inc;
          width_now_next    = width_inc;
          pending_code_next = CODE_W'(byte_q);
          if (ovf) begin
            push.cnt = 2'd2;
            push.w1  = '{code: CODE_W'(byte_q), code_bits: TOP_BITS,
                         run_last: 1'b1, block_done: last_q};
          end else if (last_q) begin
            push.cnt = 2'd2;
            push.w1  = '{code: CODE_W'(byte_q), code_bits: width_inc,
                         run_last: 1'b1, block_done: 1'b1};
          end else begin
            push.cnt         = 2'd1;
            push.w0.run_last = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (restart) begin
      pending_code_next = '0;
      at_root_next      = 1'b1;
      next_free_next    = FIRST_CODE;
      width_now_next    = START_BITS;
    end
  end

  always_ff @(posedge clk) begin
    probe_addr <= probe_addr_next;
    if (fire) begin
      byte_q <= head.data_byte;
      last_q <= head.block_end;
      key_q  <= {pending_code, head.data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      epoch        <= EP_FIRST;
      next_free    <= FIRST_CODE;
      width_now    <= START_BITS;
      pending_code <= '0;
      at_root      <= 1'b1;
    end else begin
      state        <= state_next;
      next_free    <= next_free_next;
      width_now    <= width_now_next;
      pending_code <= pending_code_next;
      at_root      <= at_root_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + HASH_W'(1);
      if (clr_done) epoch <= EP_FIRST;
      else if (restart) epoch <= epoch + EP_W'(1);
    end
  end
endmodule

### design/lzwe_out_fifo.sv
// ----------------------------------------------------------------------------
// LZW encoder output queue
// Four-entry queue taking up to two code words a cycle.
// ----------------------------------------------------------------------------
module lzwe_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  lzwe_pkg::push_t push,
  output logic            room,
  lzwe_out_if.source      code_out
);
  import lzwe_pkg::*;

  out_word_t           slots [OFIFO_D];
  logic [OFIFO_AW-1:0] wp;
  logic [OFIFO_AW-1:0] rp;
  logic [OFIFO_AW:0]   count;
  logic                pop;
  out_word_t           head;

  assign room     = (count <= (OFIFO_AW+1)'(OFIFO_D - 2));
  assign pop      = code_out.valid && code_out.ready;
  assign head     = slots[rp];
  assign code_out.valid      = (count != '0);
  assign code_out.code       = head.code;
  assign code_out.code_bits  = head.code_bits;
  assign code_out.run_last   = head.run_last;
  assign code_out.block_done = head.block_done;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) slots[wp] <= push.w0;
    if (push.cnt == 2'd2) slots[wp + OFIFO_AW'(1)] <= push.w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + OFIFO_AW'(push.cnt);
      if (pop) rp <= rp + OFIFO_AW'(1);
      count <= count + (OFIFO_AW+1)'(push.cnt) - (OFIFO_AW+1)'(pop);
    end
  end
endmodule

### design/lzw_encoder_9_to_12_bit.sv
// ----------------------------------------------------------------------------
// LZW encoder, 9 to 12 bit codes
// Byte-in, code-out LZW compressor with a hashed dictionary.
// ----------------------------------------------------------------------------
// byte_in carries one raw byte per word with block_end on the last byte of
// a block. code_out carries the emitted codes, each with its width (9..12),
// run_last on the last code caused by a byte and block_done on the last code
// of a block. A byte causes zero, one or two codes.
// In the dictionary engine a byte takes a lookup read, then a compare and
// insert, plus one further probe per hash collision; the first byte after a
// restart skips the compare and insert. The two-entry input queue accepts words
// back to back while it has room, the engine takes no new byte while it is
// probing the last one, and a four-entry output queue sits behind it.
// After reset the engine sweeps the 8192-slot dictionary once before it
// takes bytes; the same sweep recurs after every 255 dictionary restarts.
// When code_out stalls, the output queue fills, the engine stops and the
// input queue then drops ready; nothing is lost.
// ----------------------------------------------------------------------------
module lzw_encoder_9_to_12_bit (
  input  logic       clk,
  input  logic       rst,
  lzwe_in_if.sink    byte_in,
  lzwe_out_if.source code_out
);
  import lzwe_pkg::*;

  logic     avail;
  logic     pop;
  logic     room;
  in_word_t head;
  push_t    push;

  lzwe_in_fifo u_in_fifo (
    .clk(clk), .rst(rst), .byte_in(byte_in), .pop(pop), .avail(avail), .head(head)
  );

  lzwe_core u_core (
    .clk(clk), .rst(rst), .avail(avail), .head(head), .pop(pop),
    .out_room(room), .push(push)
  );

  lzwe_out_fifo u_out_fifo (
    .clk(clk), .rst(rst), .push(push), .room(room), .code_out(code_out)
  );
endmodule

### design/lzwe_checker.sv
// ----------------------------------------------------------------------------
// LZW encoder port checker
// Port-level checks on the code channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzw_encoder_9_to_12_bit_defines.svh"

module lzwe_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] code,
  input logic [3:0]  code_bits,
  input logic        run_last,
  input logic        block_done
);
  import lzwe_pkg::*;

  `LZWE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(code), "code dropped")
  `LZWE_ASSERT_NOW(a_bits, out_valid, code_bits >= START_BITS && code_bits <= TOP_BITS, "bad width")
  `LZWE_ASSERT_NOW(a_done, out_valid && block_done, run_last, "block_done without run_last")
  `LZWE_ASSERT_NOW(a_fit, out_valid && code_bits == START_BITS, code[11:9] == 3'd0, "code too wide")
endmodule

bind lzw_encoder_9_to_12_bit lzwe_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(code_out.valid), .out_ready(code_out.ready),
  .code(code_out.code), .code_bits(code_out.code_bits),
  .run_last(code_out.run_last), .block_done(code_out.block_done)
);

### tb/lzw_code_board.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW code scoreboard
// Predicts the codes of each accepted byte with its own dictionary and
// checks every code word leaving the encoder against the oldest prediction.
// ----------------------------------------------------------------------------
package lzw_code_board_pkg;
  import lzwe_pkg::*;

  class lzw_code_board;
    logic [19:0]       dict_key [4096];
    int unsigned       free_code;
    int unsigned       cur_bits;
    logic [11:0]       match_code;
    bit                idle_root;
    out_word_t         codes_due[$];
    int                errors;
    int                codes_seen;
    int                blocks_seen;
    int                restarts_seen;

    function new();
      errors = 0;
      codes_seen = 0;
      blocks_seen = 0;
      restarts_seen = 0;
      restart();
    endfunction

    function void restart();
      free_code = 256;
      cur_bits = 9;
      match_code = '0;
      idle_root = 1'b1;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      out_word_t   w[$];
      out_word_t   o;
      logic [19:0] k;
      bit          hit;
      int unsigned c;
      hit = 1'b0;
      c = 0;
      if (idle_root) begin
        match_code = {4'd0, b};
        idle_root = 1'b0;
      end else begin
        k = {match_code, b};
        for (int unsigned i = 256; i < free_code && i < 4096; i++) begin
          if (!hit && dict_key[i] == k) begin
            hit = 1'b1;
            c = i;
          end
        end
        if (hit) begin
          match_code = c[11:0];
        end else begin
          o = '0;
          o.code = match_code;
          o.code_bits = cur_bits[3:0];
          w = {w, o};
          if (free_code < 4096) dict_key[free_code] = k;
          free_code++;
          if (free_code >= (1 << cur_bits)) cur_bits++;
          match_code = {4'd0, b};
          if (cur_bits > MAX_BITS) begin
            o = '0;
            o.code = match_code;
            o.code_bits = TOP_BITS;
            w = {w, o};
            restart();
            restarts_seen++;
          end
        end
      end
      if (last) begin
        if (!idle_root) begin
          o = '0;
          o.code = match_code;
          o.code_bits = cur_bits[3:0];
          w = {w, o};
        end
        restart();
        blocks_seen++;
        if (w.size() > 0) w[w.size()-1].block_done = 1'b1;
      end
      if (w.size() > 0) w[w.size()-1].run_last = 1'b1;
      codes_due = {codes_due, w};
    endfunction

    function void check_code(out_word_t got);
      out_word_t want;
      codes_seen++;
      if (codes_due.size() == 0) begin
        $display("%0t: unexpected code word %h", $time, got);
        errors++;
        return;
      end
      want = codes_due.pop_front();
      if (got.code !== want.code)
        $display("%0t: code exp %0d got %0d", $time, want.code, got.code);
      if (got.code_bits !== want.code_bits)
        $display("%0t: code_bits exp %0d got %0d", $time, want.code_bits, got.code_bits);
      if (got.run_last !== want.run_last)
        $display("%0t: run_last exp %0b got %0b", $time, want.run_last, got.run_last);
      if (got.block_done !== want.block_done)
        $display("%0t: block_done exp %0b got %0b", $time, want.block_done, got.block_done);
      if (got !== want) errors++;
    endfunction
  endclass
endpackage

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW encoder testbench
// Drives byte blocks (directed, repetitive, random, long blocks) with
// random idling and a long output hold-off; checks every code.
// ----------------------------------------------------------------------------
module tb;
  import lzwe_pkg::*;
  import lzw_code_board_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  lzwe_in_if  byte_in ();
  lzwe_out_if code_out ();
  lzw_code_board board = new();
  bit   send_done = 1'b0;
  bit   quiet = 1'b0;
  bit   held = 1'b0;
  int   hold_cycles = 0;
  int   bytes_sent = 0;

  lzw_encoder_9_to_12_bit i_dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .code_out(code_out)
  );

  always #2 clk = ~clk;

  initial begin
    byte_in.valid = 1'b0;
    byte_in.data_byte = '0;
    byte_in.block_end = 1'b0;
    code_out.ready = 1'b0;
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < 8) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.data_byte <= b;
    byte_in.block_end <= last;
    @(posedge clk);
    while (!byte_in.ready) @(posedge clk);
    board.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_block(input int len, input int mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'($urandom_range(255));
        1: b = 8'($urandom_range(3));
        2: b = 8'(i);
        default: b = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1));
      endcase
      send_word(b, i == len - 1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b1);
    send_word(8'h41, 1'b0);
    send_word(8'h41, 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(8'h55, 1'b0);
    send_word(8'haa, 1'b0);
    send_word(8'h55, 1'b1);
    quiet = 1'b1;
    send_block(120, 1);
    quiet = 1'b0;
    send_block(350, 0);
    send_block(100, 1);
    for (int n = 0; n < 20; n++)
      send_block(int'($urandom_range(1, 30)), int'($urandom_range(3)));
    byte_in.valid <= 1'b0;
    send_done = 1'b1;
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        code_out.ready <= 1'b0;
      end else if (!held && bytes_sent >= 40) begin
        held = 1'b1;
        hold_cycles = 200;
        code_out.ready <= 1'b0;
      end else if (quiet) begin
        code_out.ready <= 1'b1;
      end else begin
        code_out.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && code_out.valid && code_out.ready) begin
      board.check_code({code_out.code, code_out.code_bits, code_out.run_last,
                        code_out.block_done});
    end
  end

  initial begin
    wait (send_done);
    while (board.codes_due.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d bytes in %0d blocks, %0d codes checked, %0d width restarts.",
             bytes_sent, board.blocks_seen, board.codes_seen, board.restarts_seen);
    if (board.errors == 0 && board.codes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
